FILE: src/prpe_pkg.sv
package prpe_pkg;

  localparam logic [1:0] POL_LRU   = 2'd0;
  localparam logic [1:0] POL_FIFO  = 2'd1;
  localparam logic [1:0] POL_CLOCK = 2'd2;

  localparam logic [1:0] CFG_POLICY = 2'd0;
  localparam logic [1:0] CFG_WAYS   = 2'd1;

  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 4;
  localparam int IN_PAGE_BITS  = 16;
  localparam int WAY_OUT_BITS  = 3;
  localparam int COUNT_BITS    = 32;

  typedef logic [COUNT_BITS-1:0] count_t;

endpackage

FILE: src/page_replacement_policy_engine_core.sv
// Fully associative page store with LRU, FIFO and second-chance clock replacement.
// Page numbers sit in a single-port-read RAM of WAYS entries; valid, recency
// and reference bits sit in flops. One request at a time: an access reads
// every frame in use (ways_in_use, clamped to 1..WAYS), one per cycle, for
// the tag match and the LRU victim; a decide state and two finish states
// follow, and the last of them registers the result once the output
// register is free. Under the clock policy a miss on a full store adds a
// pointer sweep before the finish states. A clear goes straight to the last
// finish state. The next request can be taken in the cycle in which the
// result appears, even while that result still waits on out_stall_i.
module page_replacement_policy_engine_core #(
  parameter int WAYS      = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [prpe_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [prpe_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                command_i,
  input  logic [prpe_pkg::IN_PAGE_BITS-1:0]   page_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                hit_o,
  output logic [prpe_pkg::WAY_OUT_BITS-1:0]   way_used_o,
  output logic                                evicted_valid_o,
  output logic [prpe_pkg::IN_PAGE_BITS-1:0]   evicted_page_o,
  output prpe_pkg::count_t                    hit_count_o,
  output prpe_pkg::count_t                    access_count_o
);
  import prpe_pkg::*;

  localparam int IW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CW = $clog2(WAYS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_CLOCK  = 3'd3;
  localparam logic [2:0] S_FIN0   = 3'd4;
  localparam logic [2:0] S_FIN1   = 3'd5;

  logic [2:0]           st_q, st_d;
  logic [1:0]           policy_q, policy_d;
  logic [3:0]           ways_q, ways_d;
  logic                 valid_q [WAYS];
  logic                 valid_d [WAYS];
  logic [IW-1:0]        rank_q [WAYS];
  logic [IW-1:0]        rank_d [WAYS];
  logic                 ref_q [WAYS];
  logic                 ref_d [WAYS];
  logic [CW-1:0]        occ_q, occ_d;
  logic [IW-1:0]        ptr_q, ptr_d;
  count_t               hits_q, hits_d;
  count_t               acc_q, acc_d;
  logic                 clr_q, clr_d;
  logic [PAGE_BITS-1:0] page_q, page_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 cmp_v_q, cmp_v_d;
  logic [IW-1:0]        cmp_idx_q, cmp_idx_d;
  logic                 hit_q, hit_d;
  logic [IW-1:0]        hit_idx_q, hit_idx_d;
  logic [IW-1:0]        best_q, best_d;
  logic [IW-1:0]        way_q, way_d;
  logic                 ev_q, ev_d;

  logic                 out_v_q, out_v_d;
  logic                 o_hit_q, o_hit_d;
  logic [WAY_OUT_BITS-1:0] o_way_q, o_way_d;
  logic                 o_ev_q, o_ev_d;
  logic [IN_PAGE_BITS-1:0] o_evp_q, o_evp_d;
  count_t               o_hc_q, o_hc_d;
  count_t               o_ac_q, o_ac_d;

  logic                 ram_we, ram_re;
  logic [IW-1:0]        ram_waddr, ram_raddr;
  logic [PAGE_BITS-1:0] ram_rdata;

  logic [CW-1:0]        lim;
  logic                 in_acc;
  logic                 out_free;
  logic [31:0]          page_ext, way_ext, evp_ext;

  prpe_ram #(.WIDTH(PAGE_BITS), .DEPTH(WAYS)) u_page_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(page_q),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    if (ways_q == 4'd0) begin
      lim = CW'(1);
    end else if (32'(ways_q) > 32'(WAYS)) begin
      lim = CW'(WAYS);
    end else begin
      lim = CW'(ways_q);
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (st_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !(out_v_q && out_stall_i);
  assign page_ext    = 32'(page_i);

  always_comb begin
    logic [CW-1:0] nxt;
    logic          age_all;
    logic [IW-1:0] old_rank;
    st_d      = st_q;
    policy_d  = policy_q;
    ways_d    = ways_q;
    valid_d   = valid_q;
    rank_d    = rank_q;
    ref_d     = ref_q;
    occ_d     = occ_q;
    ptr_d     = ptr_q;
    hits_d    = hits_q;
    acc_d     = acc_q;
    clr_d     = clr_q;
    page_d    = page_q;
    cnt_d     = cnt_q;
    cmp_v_d   = 1'b0;
    cmp_idx_d = cmp_idx_q;
    hit_d     = hit_q;
    hit_idx_d = hit_idx_q;
    best_d    = best_q;
    way_d     = way_q;
    ev_d      = ev_q;
    out_v_d   = out_v_q && out_stall_i;
    o_hit_d   = o_hit_q;
    o_way_d   = o_way_q;
    o_ev_d    = o_ev_q;
    o_evp_d   = o_evp_q;
    o_hc_d    = o_hc_q;
    o_ac_d    = o_ac_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = way_q;
    ram_raddr = cnt_q[IW-1:0];
    nxt       = CW'(ptr_q) + CW'(1);
    age_all   = 1'b0;
    old_rank  = '0;
    way_ext   = '0;
    evp_ext   = '0;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_POLICY: policy_d = cfg_wdata_i[1:0];
        CFG_WAYS:   ways_d   = cfg_wdata_i;
        default: ;
      endcase
    end

    unique case (st_q)
      S_IDLE: begin
        if (in_acc) begin
          page_d = page_ext[PAGE_BITS-1:0];
          if (command_i == CMD_CLEAR) begin
            for (int i = 0; i < WAYS; i++) begin
              valid_d[i] = 1'b0;
              rank_d[i]  = '0;
              ref_d[i]   = 1'b0;
            end
            occ_d  = '0;
            ptr_d  = '0;
            hits_d = '0;
            acc_d  = '0;
            clr_d  = 1'b1;
            st_d   = S_FIN1;
          end else begin
            clr_d  = 1'b0;
            if (CW'(ptr_q) >= lim) begin
              ptr_d = '0;
            end
            cnt_d  = '0;
            hit_d  = 1'b0;
            best_d = '0;
            ev_d   = 1'b0;
            st_d   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cnt_q < lim) begin
          ram_re    = 1'b1;
          cmp_v_d   = 1'b1;
          cmp_idx_d = cnt_q[IW-1:0];
          cnt_d     = cnt_q + CW'(1);
        end else if (!cmp_v_q) begin
          st_d = S_DECIDE;
        end
        if (cmp_v_q) begin
          if (!hit_q && valid_q[cmp_idx_q] && ram_rdata == page_q) begin
            hit_d     = 1'b1;
            hit_idx_d = cmp_idx_q;
          end
          if (rank_q[cmp_idx_q] > rank_q[best_q]) begin
            best_d = cmp_idx_q;
          end
        end
      end
      S_DECIDE: begin
        cnt_d = '0;
        st_d  = S_FIN0;
        if (hit_q) begin
          way_d = hit_idx_q;
        end else if (occ_q < lim) begin
          way_d = occ_q[IW-1:0];
          occ_d = occ_q + CW'(1);
        end else begin
          ev_d = 1'b1;
          case (policy_q)
            POL_FIFO:  way_d = ptr_q;
            POL_CLOCK: st_d  = S_CLOCK;
            default:   way_d = best_q;
          endcase
        end
      end
      S_CLOCK: begin
        if (cnt_q == lim || !ref_q[ptr_q]) begin
          way_d = ptr_q;
          st_d  = S_FIN0;
        end else begin
          ref_d[ptr_q] = 1'b0;
          ptr_d = (nxt == lim) ? '0 : nxt[IW-1:0];
          cnt_d = cnt_q + CW'(1);
        end
      end
      S_FIN0: begin
        ram_re    = 1'b1;
        ram_raddr = way_q;
        st_d      = S_FIN1;
      end
      S_FIN1: begin
        if (out_free) begin
          out_v_d = 1'b1;
          st_d    = S_IDLE;
          if (clr_q) begin
            o_hit_d = 1'b0;
            o_way_d = '0;
            o_ev_d  = 1'b0;
            o_evp_d = '0;
            o_hc_d  = '0;
            o_ac_d  = '0;
          end else begin
            old_rank = rank_q[way_q];
            age_all  = !hit_q;
            for (int i = 0; i < WAYS; i++) begin
              if (IW'(i) != way_q && valid_q[i] && (age_all || rank_q[i] < old_rank)
                  && rank_q[i] < IW'(WAYS - 1)) begin
                rank_d[i] = rank_q[i] + IW'(1);
              end
            end
            rank_d[way_q] = '0;
            ref_d[way_q]  = 1'b1;
            if (!hit_q) begin
              ram_we         = 1'b1;
              valid_d[way_q] = 1'b1;
              nxt            = CW'(way_q) + CW'(1);
              ptr_d          = (nxt == lim) ? '0 : nxt[IW-1:0];
            end
            if (hit_q && hits_q != '1) begin
              hits_d = hits_q + count_t'(1);
            end
            if (acc_q != '1) begin
              acc_d = acc_q + count_t'(1);
            end
            way_ext = 32'(way_q);
            evp_ext = 32'(ram_rdata);
            o_hit_d = hit_q;
            o_way_d = way_ext[WAY_OUT_BITS-1:0];
            o_ev_d  = ev_q;
            o_evp_d = ev_q ? evp_ext[IN_PAGE_BITS-1:0] : '0;
            o_hc_d  = (hit_q && hits_q != '1) ? hits_q + count_t'(1) : hits_q;
            o_ac_d  = (acc_q != '1) ? acc_q + count_t'(1) : acc_q;
          end
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      policy_q <= POL_LRU;
      ways_q   <= 4'd8;
      for (int i = 0; i < WAYS; i++) begin
        valid_q[i] <= 1'b0;
        rank_q[i]  <= '0;
        ref_q[i]   <= 1'b0;
      end
      occ_q    <= '0;
      ptr_q    <= '0;
      hits_q   <= '0;
      acc_q    <= '0;
      clr_q    <= 1'b0;
      cnt_q    <= '0;
      cmp_v_q  <= 1'b0;
      hit_q    <= 1'b0;
      ev_q     <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      st_q     <= st_d;
      policy_q <= policy_d;
      ways_q   <= ways_d;
      valid_q  <= valid_d;
      rank_q   <= rank_d;
      ref_q    <= ref_d;
      occ_q    <= occ_d;
      ptr_q    <= ptr_d;
      hits_q   <= hits_d;
      acc_q    <= acc_d;
      clr_q    <= clr_d;
      cnt_q    <= cnt_d;
      cmp_v_q  <= cmp_v_d;
      hit_q    <= hit_d;
      ev_q     <= ev_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q    <= page_d;
    cmp_idx_q <= cmp_idx_d;
    hit_idx_q <= hit_idx_d;
    best_q    <= best_d;
    way_q     <= way_d;
    o_hit_q   <= o_hit_d;
    o_way_q   <= o_way_d;
    o_ev_q    <= o_ev_d;
    o_evp_q   <= o_evp_d;
    o_hc_q    <= o_hc_d;
    o_ac_q    <= o_ac_d;
  end

  assign out_valid_o     = out_v_q;
  assign hit_o           = o_hit_q;
  assign way_used_o      = o_way_q;
  assign evicted_valid_o = o_ev_q;
  assign evicted_page_o  = o_evp_q;
  assign hit_count_o     = o_hc_q;
  assign access_count_o  = o_ac_q;

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("request taken while busy");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(occ_q) <= 32'(WAYS))
    else $error("occupancy above frame count");

  a_result_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(st_q) == S_FIN1)
    else $error("result loaded outside commit");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && o_hit_q) |-> !o_ev_q)
    else $error("hit reported with eviction");

endmodule

FILE: src/prpe_ram.sv
module prpe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
